@@ src/mmn_pkg.sv @@
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants for the min-max normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

    localparam int VAL_W     = 32;  // Q15.16 input value
    localparam int QUOT_W    = 17;  // 0..65536, 16 fraction bits
    localparam int DIV_STEPS = 17;  // one quotient bit per step
    localparam int STEP_W    = 5;
    localparam int OUT_TDATA_W = 24;

    localparam logic [VAL_W-1:0] VAL_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MOST_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/min_max_normalizer.sv @@
// ----------------------------------------------------------------------------
// min_max_normalizer
// Stores a vector of Q15.16 values, tracks min and max, then emits each
// value as (value - min) * 65536 / (max - min) through a shared divider, or 0 when max equals min.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                  | tuser      | tlast
//  --------+-----+------------------------+------------+-----------
//  s_      | in  | [31:0] value           | -          | last
//  m_      | out | [16:0] normalized, pad | degenerate | final_res
//
//  Loading: one value per cycle until the request marked last.
//  Emission: each result passes memory read, operand setup, 17 divider
//  steps plus completion, then output load; the divider steps are skipped
//  when max equals min (no division).
//  s_tready is low for the whole emission burst. Reset needs no clearing pass.
//  A stalled m_ side holds the sequencer in its output step.
//
module min_max_normalizer #(
    parameter int MAX_VALUES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] normalized, [23:17] zero
    output logic        m_tuser,   // [0] degenerate
    output logic        m_tlast    // final_res
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int AW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    mmn_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          rd_idx_reg;
    logic [mmn_pkg::VAL_W-1:0] min_reg;
    logic [mmn_pkg::VAL_W-1:0] max_reg;
    logic                      degen_reg;

    logic                       m_valid_reg;
    logic [mmn_pkg::QUOT_W-1:0] m_norm_reg;
    logic                       m_degen_reg;
    logic                       m_final_reg;

    logic                       s_accept;
    logic                       room;
    logic                       is_final;
    logic                       out_load;
    logic                       div_start;
    logic                       rd_en;
    logic                       span_zero;
    logic [mmn_pkg::VAL_W-1:0]  rd_data;
    logic [mmn_pkg::VAL_W:0]    d_wide;
    logic [mmn_pkg::VAL_W:0]    span_wide;
    mmn_pkg::div_status_t       div_status;
    logic [mmn_pkg::QUOT_W-1:0] quotient;

    assign s_accept  = s_tvalid && s_tready;
    assign room      = (count_reg < CNT_W'(MAX_VALUES));
    assign is_final  = ((rd_idx_reg + CNT_W'(1)) == count_reg);
    assign d_wide    = {rd_data[mmn_pkg::VAL_W-1], rd_data} - {min_reg[mmn_pkg::VAL_W-1], min_reg};
    assign span_wide = {max_reg[mmn_pkg::VAL_W-1], max_reg} - {min_reg[mmn_pkg::VAL_W-1], min_reg};
    assign span_zero = (max_reg == min_reg);

    mmn_store #(
        .DEPTH (MAX_VALUES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept && room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    mmn_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (d_wide[mmn_pkg::VAL_W-1:0]),
        .divisor  (span_wide[mmn_pkg::VAL_W-1:0]),
        .status   (div_status),
        .quotient (quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmn_pkg::ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = mmn_pkg::ST_READ;
                end
            end
            mmn_pkg::ST_READ: begin
                state_next = mmn_pkg::ST_SETUP;
            end
            mmn_pkg::ST_SETUP: begin
                state_next = span_zero ? mmn_pkg::ST_OUT : mmn_pkg::ST_DIV;
            end
            mmn_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = mmn_pkg::ST_OUT;
                end
            end
            mmn_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = is_final ? mmn_pkg::ST_LOAD : mmn_pkg::ST_READ;
                end
            end
            default: state_next = mmn_pkg::ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            mmn_pkg::ST_LOAD:  s_tready  = 1'b1;
            mmn_pkg::ST_READ:  rd_en     = 1'b1;
            mmn_pkg::ST_SETUP: div_start = !span_zero;
            mmn_pkg::ST_DIV:   ;
            mmn_pkg::ST_OUT:   out_load  = !m_valid_reg || m_tready;
            default:           ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmn_pkg::ST_LOAD;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            min_reg     <= mmn_pkg::VAL_MOST_POS;
            max_reg     <= mmn_pkg::VAL_MOST_NEG;
            degen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept && room) begin
                count_reg <= count_reg + CNT_W'(1);
                if ($signed(s_tdata) < $signed(min_reg)) begin
                    min_reg <= s_tdata;
                end
                if ($signed(s_tdata) > $signed(max_reg)) begin
                    max_reg <= s_tdata;
                end
            end
            if (state_reg == mmn_pkg::ST_SETUP) begin
                degen_reg <= span_zero;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (is_final) begin
                    // vector done: back to reset values for the next one
                    count_reg  <= '0;
                    rd_idx_reg <= '0;
                    min_reg    <= mmn_pkg::VAL_MOST_POS;
                    max_reg    <= mmn_pkg::VAL_MOST_NEG;
                end else begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_norm_reg  <= degen_reg ? '0 : quotient;
            m_degen_reg <= degen_reg;
            m_final_reg <= is_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mmn_pkg::OUT_TDATA_W - mmn_pkg::QUOT_W){1'b0}}, m_norm_reg};
    assign m_tuser  = m_degen_reg;
    assign m_tlast  = m_final_reg;

`ifndef SYNTHESIS
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && is_final) |=> (count_reg == '0 && state_reg == mmn_pkg::ST_LOAD))
        else $error("vector state not cleared after final result");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_status.done && state_reg == mmn_pkg::ST_DIV)
        |-> (quotient <= mmn_pkg::QUOT_W'(65536)))
        else $error("normalized value above 1.0");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != mmn_pkg::ST_LOAD) |-> (rd_idx_reg < count_reg))
        else $error("read index beyond stored count");

    a_div_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmn_pkg::ST_DIV) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle divider");
`endif

endmodule

@@ src/mmn_store.sv @@
// ----------------------------------------------------------------------------
// mmn_store
// Value memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmn_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [mmn_pkg::VAL_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [mmn_pkg::VAL_W-1:0] rd_data
);

    logic [mmn_pkg::VAL_W-1:0] mem [DEPTH];
    logic [mmn_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mmn_divider.sv @@
// ----------------------------------------------------------------------------
// mmn_divider
// Restoring divider: (dividend * 65536) / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mmn_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mmn_pkg::VAL_W-1:0]  dividend,
    input  logic [mmn_pkg::VAL_W-1:0]  divisor,
    output mmn_pkg::div_status_t       status,
    output logic [mmn_pkg::QUOT_W-1:0] quotient
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [mmn_pkg::STEP_W-1:0] step_reg, step_next;
    logic [mmn_pkg::VAL_W-1:0]  rem_reg, rem_next;
    logic [mmn_pkg::VAL_W-1:0]  dvsr_reg, dvsr_next;
    // numerator bits shift out at the top, quotient bits shift in at the bottom
    logic [mmn_pkg::QUOT_W-1:0] nq_reg, nq_next;

    logic [mmn_pkg::VAL_W:0]    shifted;
    logic [mmn_pkg::VAL_W:0]    diff;
    logic                       qbit;

    assign shifted = {rem_reg, nq_reg[mmn_pkg::QUOT_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign qbit    = (shifted >= {1'b0, dvsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        nq_next   = nq_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            // numerator is dividend << 16; top 31 bits preload the remainder
            rem_next  = {1'b0, dividend[mmn_pkg::VAL_W-1:1]};
            nq_next   = {dividend[0], {(mmn_pkg::QUOT_W-1){1'b0}}};
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[mmn_pkg::VAL_W-1:0] : shifted[mmn_pkg::VAL_W-1:0];
            nq_next  = {nq_reg[mmn_pkg::QUOT_W-2:0], qbit};
            step_next = step_reg + mmn_pkg::STEP_W'(1);
            if (step_reg == mmn_pkg::STEP_W'(mmn_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        nq_reg   <= nq_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = nq_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of min_max_normalizer. Vectors of Q15.16 values go in
// on the s_ side; a scoreboard predicts each normalized burst and compares
// it field by field with the m_ side. The run has three idling profiles and
// one long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STORE_CAP   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {
        PH_RECV_SLOW,   // sender idles 33%, receiver 76%
        PH_SEND_SLOW,   // sender idles 76%, receiver 33%
        PH_FULL_RATE    // no idling
    } phase_e;

    typedef enum int {
        PAT_SPREAD,     // any 32-bit value
        PAT_NARROW,     // small offsets around a random base
        PAT_FLAT,       // every value equal
        PAT_CORNER      // extremes, zero, +-1
    } value_pattern_e;

    typedef struct {
        logic [mmn_pkg::VAL_W-1:0] value;
        logic                      last;
    } sample_t;

    typedef struct packed {
        logic [mmn_pkg::QUOT_W-1:0] normalized;
        logic                       degenerate;
        logic                       final_res;
    } norm_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    min_max_normalizer #(.MAX_VALUES(STORE_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),   // last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [16:0] normalized, [23:17] zero
        .m_tuser  (m_tuser),   // [0] degenerate
        .m_tlast  (m_tlast)    // final_res
    );

    always #5 aclk = ~aclk;

    // stimulus and expectations
    sample_t      pending_samples[$];
    norm_result_t expected_norms[$];

    phase_e phase         = PH_RECV_SLOW;
    int     send_idle_pct = 33;
    int     recv_idle_pct = 76;
    logic   recv_hold     = 1'b0;
    logic   s_taken       = 1'b0;

    // shadow of the vector being loaded
    int vec_store[STORE_CAP];
    int vec_count;
    int vec_min;
    int vec_max;

    int errors        = 0;
    int cycles        = 0;
    int items_in      = 0;
    int ignored_in    = 0;
    int vectors_done  = 0;
    int results_out   = 0;
    int flat_results  = 0;
    int full_vectors  = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic clear_vector();
        vec_count = 0;
        vec_min   = mmn_pkg::VAL_MOST_POS;
        vec_max   = mmn_pkg::VAL_MOST_NEG;
    endtask

    // Update the shadow vector; a last request queues the whole burst.
    task automatic absorb_sample(input sample_t s);
        int           v;
        longint       span;
        longint       diff;
        longint       quo;
        bit           flat;
        norm_result_t r;
        v = $signed(s.value);
        if (vec_count < STORE_CAP) begin
            vec_store[vec_count] = v;
            vec_count++;
            if (v < vec_min) vec_min = v;
            if (v > vec_max) vec_max = v;
        end else begin
            ignored_in++;
        end
        if (s.last) begin
            if (vec_count == STORE_CAP) full_vectors++;
            span = longint'(vec_max) - longint'(vec_min);
            flat = (span == 0);
            for (int k = 0; k < vec_count; k++) begin
                quo = 0;
                if (!flat) begin
                    diff = longint'(vec_store[k]) - longint'(vec_min);
                    quo  = (diff * 65536) / span;
                    if (quo > 65536) quo = 65536;
                end
                r.normalized = quo[mmn_pkg::QUOT_W-1:0];
                r.degenerate = flat;
                r.final_res  = (k + 1 == vec_count);
                expected_norms.insert(expected_norms.size(), r);
            end
            vectors_done++;
            clear_vector();
        end
    endtask

    // request side driver
    always @(negedge aclk) begin
        sample_t s;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= s.value;
                s_tlast  <= s.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready
    always @(negedge aclk) begin
        if (!aresetn || recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        sample_t      s;
        norm_result_t want;
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                s.value = s_tdata;
                s.last  = s_tlast;
                items_in++;
                absorb_sample(s);
            end
            if (m_tvalid && m_tready) begin
                results_out++;
                if (m_tuser) flat_results++;
                if (expected_norms.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_tdata, -1);
                end else begin
                    want = expected_norms.pop_front();
                    if (m_tdata[mmn_pkg::QUOT_W-1:0] !== want.normalized)
                        report_mismatch("normalized", m_tdata[mmn_pkg::QUOT_W-1:0],
                                        want.normalized);
                    if (m_tdata[23:mmn_pkg::QUOT_W] !== '0)
                        report_mismatch("tdata pad", m_tdata[23:mmn_pkg::QUOT_W], 0);
                    if (m_tuser !== want.degenerate)
                        report_mismatch("degenerate", m_tuser, want.degenerate);
                    if (m_tlast !== want.final_res)
                        report_mismatch("final_res", m_tlast, want.final_res);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_norms.size());
            $display("min_max_normalizer verification failed");
            $finish;
        end
    end

    task automatic push_sample(input logic [31:0] value, input logic last);
        sample_t s;
        s.value = value;
        s.last  = last;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    function automatic logic [31:0] pattern_value(input value_pattern_e pat,
                                                  input logic [31:0] base,
                                                  input int spread);
        logic [31:0] v;
        case (pat)
            PAT_SPREAD: v = $urandom();
            PAT_NARROW: v = base + $urandom_range(spread);
            PAT_FLAT:   v = base;
            default: begin
                case ($urandom_range(5))
                    0: v = mmn_pkg::VAL_MOST_NEG;
                    1: v = mmn_pkg::VAL_MOST_POS;
                    2: v = 32'h0;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h1;
                    default: v = $urandom();
                endcase
            end
        endcase
        return v;
    endfunction

    // Queue one vector; returns how many of its requests get stored.
    task automatic queue_vector(input int len, output int stored);
        value_pattern_e pat;
        logic [31:0]    base;
        int             spread;
        pat    = value_pattern_e'($urandom_range(3));
        base   = $urandom();
        spread = $urandom_range(1, 300);
        for (int i = 0; i < len; i++)
            push_sample(pattern_value(pat, base, spread), i == len - 1);
        stored = (len > STORE_CAP) ? STORE_CAP : len;
    endtask

    task automatic directed_vectors();
        // full signed range plus zero, -1 and 32'h0001_0000
        push_sample(mmn_pkg::VAL_MOST_NEG, 1'b0);
        push_sample(mmn_pkg::VAL_MOST_POS, 1'b0);
        push_sample(32'h0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0001_0000, 1'b1);
        // one value only: flat
        push_sample(32'h1234_5678, 1'b1);
        // all equal at both extremes
        repeat (2) push_sample(mmn_pkg::VAL_MOST_POS, 1'b0);
        push_sample(mmn_pkg::VAL_MOST_POS, 1'b1);
        push_sample(mmn_pkg::VAL_MOST_NEG, 1'b0);
        push_sample(mmn_pkg::VAL_MOST_NEG, 1'b1);
        // span of one
        push_sample(32'd5, 1'b0);
        push_sample(32'd6, 1'b0);
        push_sample(32'd5, 1'b1);
        // truncating quotients
        push_sample(32'd0, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd3, 1'b1);
        // negatives only
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'hFFFF_FFF9, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_tvalid || expected_norms.size() > 0)
            @(posedge aclk);
    endtask

    // long receiver hold while the sender keeps offering
    initial begin
        wait (phase == PH_FULL_RATE);
        @(negedge aclk);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        @(negedge aclk);
        recv_hold = 1'b0;
    end

    initial begin
        int phase_items;
        int stored;
        int len;
        clear_vector();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int p = PH_RECV_SLOW; p <= PH_FULL_RATE; p++) begin
            phase = phase_e'(p);
            case (phase)
                PH_RECV_SLOW: begin send_idle_pct = 33; recv_idle_pct = 76; end
                PH_SEND_SLOW: begin send_idle_pct = 76; recv_idle_pct = 33; end
                default:      begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            if (phase == PH_RECV_SLOW) directed_vectors();
            // each phase opens with a vector that fills the store, maybe past it (the first after its directed vectors)
            queue_vector(STORE_CAP + $urandom_range(4), stored);
            phase_items = stored;
            while (phase_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(11) == 0)
                    len = $urandom_range(STORE_CAP - 4, STORE_CAP + 4);
                else
                    len = $urandom_range(1, 12);
                queue_vector(len, stored);
                phase_items += stored;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_norms.size() > 0)
            report_mismatch("results never delivered", 0, expected_norms.size());

        $display("covered %0d vectors from %0d requests (%0d past a full store, %0d full)",
                 vectors_done, items_in, ignored_in, full_vectors);
        $display("checked %0d normalized results, %0d of them flat, %0d mismatches",
                 results_out, flat_results, errors);
        if (errors == 0)
            $display("min_max_normalizer verification clean");
        else
            $display("min_max_normalizer verification failed");
        $finish;
    end

endmodule
